// ----- rtl/core/nph_pkg.sv -----
// ----------------------------------------------------------------------------
// nph_pkg: shared types and constants of the nearest point search
// Field widths, angle constants, the CORDIC arctangent table and the item
// records that pass between the front queue, distance engine and selector.
// ----------------------------------------------------------------------------
package nph_pkg;

	localparam int LAT_W  = 24;
	localparam int LON_W  = 25;
	localparam int IDX_W  = 16;
	localparam int DIST_W = 19;
	localparam int MUL_W  = 32;
	localparam int PROD_W = 64;

	// Degrees times 65536
	localparam logic signed [25:0] DEG360 = 26'sd23592960;
	localparam logic signed [25:0] DEG180 = 26'sd11796480;
	localparam logic signed [25:0] DEG90  = 26'sd5898240;

	// pi/180 in Q44, multiplied as two partial products (low 20 bits, high 19 bits)
	localparam logic [38:0] RAD_Q44   = 39'd307041569099;
	localparam int          RAD_LO_W  = 20;
	// CORDIC gain in Q30
	localparam logic [31:0] GAIN_Q30  = 32'd652032874;
	// Earth diameter in km times 16
	localparam logic [17:0] KM16_DIAM = 18'd203872;
	localparam logic [DIST_W-1:0] DIST_MAX = 19'd320240;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_QUERY_LAT = 1'b0,
		REG_QUERY_LON = 1'b1
	} nph_reg_t;

	// Candidate point as held in the queue
	typedef struct packed {
		logic signed [LON_W-1:0] lon;
		logic signed [LAT_W-1:0] lat;
		logic                    last;
	} nph_item_t;

	// Distance of one candidate handed to the selector
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              last;
	} nph_dist_t;

	// atan(2^-i) in radians, Q30, truncated
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		begin
			unique case (i)
				5'd0:    v = 32'h3243F6A8;
				5'd1:    v = 32'h1DAC6705;
				5'd2:    v = 32'h0FADBAFC;
				5'd3:    v = 32'h07F56EA6;
				5'd4:    v = 32'h03FEAB76;
				5'd5:    v = 32'h01FFD55B;
				5'd6:    v = 32'h00FFFAAA;
				5'd7:    v = 32'h007FFF55;
				5'd8:    v = 32'h003FFFEA;
				5'd9:    v = 32'h001FFFFD;
				5'd10:   v = 32'h000FFFFF;
				5'd11:   v = 32'h0007FFFF;
				5'd12:   v = 32'h0003FFFF;
				5'd13:   v = 32'h0001FFFF;
				5'd14:   v = 32'h0000FFFF;
				5'd15:   v = 32'h00007FFF;
				5'd16:   v = 32'h00003FFF;
				5'd17:   v = 32'h00001FFF;
				5'd18:   v = 32'h00000FFF;
				5'd19:   v = 32'h000007FF;
				5'd20:   v = 32'h000003FF;
				5'd21:   v = 32'h000001FF;
				5'd22:   v = 32'h000000FF;
				5'd23:   v = 32'h0000007F;
				default: v = 32'h00000000;
			endcase
			return v;
		end
	endfunction

endpackage

// ----- rtl/core/nph_front.sv -----
// ----------------------------------------------------------------------------
// nph_front: input acceptance and item queue
// Takes candidate items from the stream port and holds them in a short
// queue so the distance engine and the upstream source stall independently.
// ----------------------------------------------------------------------------
module nph_front
	import nph_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [55:0]     s_tdata,
	input  logic            s_tlast,
	output nph_item_t       item,
	output logic            item_valid,
	input  logic            item_ready
);

	localparam int QD = 4;
	localparam int PW = $clog2(QD);

	nph_item_t       queue_q [QD];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	logic            push;
	logic            pop;

	assign s_tready   = (count_q != (PW+1)'(QD));
	assign item_valid = (count_q != '0);
	assign item       = queue_q[rd_ptr_q];
	assign push       = s_tvalid && s_tready;
	assign pop        = item_valid && item_ready;

	// Store an accepted item
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q].lat  <= s_tdata[LAT_W-1:0];
			queue_q[wr_ptr_q].lon  <= s_tdata[LAT_W+LON_W-1:LAT_W];
			queue_q[wr_ptr_q].last <= s_tlast;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/core/nph_dist.sv -----
// ----------------------------------------------------------------------------
// nph_dist: haversine distance engine
// Sequencer around one shared CORDIC stage, one 32x32 multiplier and one
// shift-subtract square root step. Produces the distance in km times 16.
// ----------------------------------------------------------------------------
module nph_dist
	import nph_pkg::*;
#(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [LAT_W-1:0] query_lat,
	input  logic signed [LON_W-1:0] query_lon,
	input  nph_item_t               item,
	input  logic                    item_valid,
	output logic                    item_ready,
	output nph_dist_t               res,
	output logic                    res_valid,
	input  logic                    res_ready
);

	localparam int WF = ANGLE_FRAC_BITS + 10;
	localparam int CW = WF + 4;
	localparam int SW = WF + 2;
	localparam int IW = $clog2(CORDIC_STEPS);
	localparam int SH = 60 - WF;
	localparam logic signed [CW-1:0]     ONE_C  = CW'(longint'(1) << WF);
	localparam logic signed [CW-1:0]     GAIN_C = CW'(GAIN_Q30 >> (30 - WF));
	localparam logic [PROD_W-1:0]        ONE_SQ = PROD_W'(1) << (2 * WF);
	localparam logic signed [PROD_W-1:0] HALF_R = PROD_W'(longint'(1) << (WF - 1));
	localparam logic signed [MUL_W-1:0]  RAD_LO =
		MUL_W'({1'b0, RAD_Q44[RAD_LO_W-1:0]});
	localparam logic signed [MUL_W-1:0]  RAD_HI =
		MUL_W'({1'b0, RAD_Q44[38:RAD_LO_W]});

	typedef enum logic [19:0] {
		ST_IDLE = 20'h00001,
		ST_RED  = 20'h00002,
		ST_MLO  = 20'h00004,
		ST_MHI  = 20'h00008,
		ST_ZIN  = 20'h00010,
		ST_ROT  = 20'h00020,
		ST_SCO  = 20'h00040,
		ST_M1   = 20'h00080,
		ST_M2   = 20'h00100,
		ST_M3   = 20'h00200,
		ST_M4   = 20'h00400,
		ST_A    = 20'h00800,
		ST_SQ   = 20'h01000,
		ST_SCL  = 20'h02000,
		ST_M5   = 20'h04000,
		ST_SQ2I = 20'h08000,
		ST_VIN  = 20'h10000,
		ST_MD   = 20'h20000,
		ST_DST  = 20'h40000,
		ST_OUT  = 20'h80000
	} state_t;

	state_t                    state_q;
	logic signed [LAT_W-1:0]   plat_q;
	logic signed [LON_W-1:0]   plon_q;
	logic                      last_q;
	logic [1:0]                job_q;
	logic                      vec_q;
	logic                      pass_q;
	logic signed [24:0]        r_q;
	logic                      neg_q;
	logic signed [CW-1:0]      x_q;
	logic signed [CW-1:0]      y_q;
	logic signed [CW-1:0]      z_q;
	logic [IW-1:0]             i_q;
	logic signed [SW-1:0]      sdl_q;
	logic signed [SW-1:0]      sdo_q;
	logic signed [SW-1:0]      cq_q;
	logic signed [SW-1:0]      cp_q;
	logic signed [SW-1:0]      t1_q;
	logic signed [SW-1:0]      t2_q;
	logic [WF:0]               s_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  lo_q;
	logic [PROD_W-1:0]         sq_v_q;
	logic [PROD_W-1:0]         sq_res_q;
	logic [PROD_W-1:0]         sq_bit_q;
	logic [4:0]                k_q;
	logic [DIST_W-1:0]         dist_q;

	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [25:0]        deg;
	logic signed [25:0]        red;
	logic signed [CW-1:0]      dx;
	logic signed [CW-1:0]      dy;
	logic signed [CW-1:0]      at;
	logic                      dir;
	logic signed [CW-1:0]      xc;
	logic signed [CW-1:0]      yc;
	logic signed [PROD_W-1:0]  z_full;
	logic signed [SW-1:0]      t4;
	logic signed [SW:0]        a_sum;
	logic [WF:0]               a_u;
	logic [PROD_W-1:0]         sq_sum;
	logic                      sq_ge;
	logic signed [CW-1:0]      zc;
	logic signed [PROD_W-1:0]  dq;

	function automatic logic signed [CW-1:0] atan_w(input logic [IW-1:0] idx);
		logic [31:0] raw;
		begin
			raw = atan_q30(5'(idx));
			return CW'(raw >> (30 - WF));
		end
	endfunction

	assign item_ready   = (state_q == ST_IDLE);
	assign res_valid    = (state_q == ST_OUT);
	assign res.distance = dist_q;
	assign res.last     = last_q;

	// Angle of the current sine/cosine job, reduced to [-180, 180)
	always_comb begin
		unique case (job_q)
			2'd0:    deg = 26'(plat_q) - 26'(query_lat);
			2'd1:    deg = 26'(plon_q) - 26'(query_lon);
			2'd2:    deg = 26'(query_lat);
			default: deg = 26'(plat_q);
		endcase
		if (deg >= DEG180)     red = deg - DEG360;
		else if (deg < -DEG180) red = deg + DEG360;
		else                   red = deg;
	end

	// One CORDIC micro-rotation, rotation or vectoring
	always_comb begin
		dx  = x_q >>> i_q;
		dy  = y_q >>> i_q;
		at  = atan_w(i_q);
		dir = vec_q ? (y_q < 0) : (z_q >= 0);
		if (x_q > ONE_C)       xc = ONE_C;
		else if (x_q < -ONE_C) xc = -ONE_C;
		else                   xc = x_q;
		if (y_q > ONE_C)       yc = ONE_C;
		else if (y_q < -ONE_C) yc = -ONE_C;
		else                   yc = y_q;
		z_full = ((prod_q <<< RAD_LO_W) + lo_q) >>> (job_q[1] ? SH : SH + 1);
		zc     = (z_q < 0) ? '0 : z_q;
	end

	// Haversine term, square root step, final scaling
	always_comb begin
		t4    = SW'(prod_q >>> WF);
		a_sum = (SW+1)'(t1_q) + (SW+1)'(t4);
		if (a_sum < 0)                    a_u = '0;
		else if (a_sum > (SW+1)'(ONE_C))  a_u = (WF+1)'(ONE_C);
		else                              a_u = a_sum[WF:0];
		sq_sum = sq_res_q + sq_bit_q;
		sq_ge  = (sq_v_q >= sq_sum);
		dq     = (prod_q + HALF_R) >>> WF;
	end

	// Select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MLO: begin
				mul_a = MUL_W'(r_q);
				mul_b = RAD_LO;
			end
			ST_MHI: begin
				mul_a = MUL_W'(r_q);
				mul_b = RAD_HI;
			end
			ST_M1: begin
				mul_a = MUL_W'(sdl_q);
				mul_b = MUL_W'(sdl_q);
			end
			ST_M2: begin
				mul_a = MUL_W'(sdo_q);
				mul_b = MUL_W'(sdo_q);
			end
			ST_M3: begin
				mul_a = MUL_W'(cq_q);
				mul_b = MUL_W'(cp_q);
			end
			ST_M4: begin
				mul_a = MUL_W'(prod_q >>> WF);
				mul_b = MUL_W'(t2_q);
			end
			ST_M5: begin
				mul_a = MUL_W'({1'b0, s_q});
				mul_b = MUL_W'({1'b0, s_q});
			end
			ST_MD: begin
				mul_a = MUL_W'(zc);
				mul_b = MUL_W'({1'b0, KM16_DIAM});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Shared multiplier, registered product
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				plat_q <= item.lat;
				plon_q <= item.lon;
				last_q <= item.last;
			end
			ST_RED: begin
				// Fold full angles into [-90, 90] and remember the cosine sign
				if (job_q[1] && (red > DEG90)) begin
					r_q   <= 25'(DEG180 - red);
					neg_q <= 1'b1;
				end else if (job_q[1] && (red < -DEG90)) begin
					r_q   <= 25'(-DEG180 - red);
					neg_q <= 1'b1;
				end else begin
					r_q   <= 25'(red);
					neg_q <= 1'b0;
				end
			end
			ST_MHI: lo_q <= prod_q;
			ST_ZIN: begin
				z_q <= CW'(z_full);
				x_q <= GAIN_C;
				y_q <= '0;
			end
			ST_ROT: begin
				x_q <= dir ? x_q - dy : x_q + dy;
				y_q <= dir ? y_q + dx : y_q - dx;
				z_q <= dir ? z_q - at : z_q + at;
			end
			ST_SCO: begin
				unique case (job_q)
					2'd0:    sdl_q <= SW'(yc);
					2'd1:    sdo_q <= SW'(yc);
					2'd2:    cq_q  <= neg_q ? SW'(-xc) : SW'(xc);
					default: cp_q  <= neg_q ? SW'(-xc) : SW'(xc);
				endcase
			end
			ST_M2: t1_q <= SW'(prod_q >>> WF);
			ST_M3: t2_q <= SW'(prod_q >>> WF);
			ST_A: begin
				sq_v_q   <= PROD_W'(a_u) << WF;
				sq_res_q <= '0;
				sq_bit_q <= PROD_W'(1) << 62;
			end
			ST_SQ: begin
				if (sq_ge) begin
					sq_v_q   <= sq_v_q - sq_sum;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			ST_SCL: begin
				if (sq_res_q > PROD_W'(ONE_C)) s_q <= (WF+1)'(ONE_C);
				else                           s_q <= sq_res_q[WF:0];
			end
			ST_SQ2I: begin
				sq_v_q   <= ONE_SQ - $unsigned(prod_q);
				sq_res_q <= '0;
				sq_bit_q <= PROD_W'(1) << 62;
			end
			ST_VIN: begin
				x_q <= CW'(sq_res_q[WF:0]);
				y_q <= CW'(s_q);
				z_q <= '0;
			end
			ST_DST: begin
				if (dq > PROD_W'(DIST_MAX)) dist_q <= DIST_MAX;
				else                        dist_q <= dq[DIST_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= '0;
			vec_q   <= 1'b0;
			pass_q  <= 1'b0;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						job_q   <= '0;
						vec_q   <= 1'b0;
						state_q <= ST_RED;
					end
				end
				ST_RED: state_q <= ST_MLO;
				ST_MLO: state_q <= ST_MHI;
				ST_MHI: state_q <= ST_ZIN;
				ST_ZIN: begin
					i_q     <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					i_q <= i_q + 1'b1;
					if (i_q == IW'(CORDIC_STEPS - 1)) begin
						state_q <= vec_q ? ST_MD : ST_SCO;
					end
				end
				ST_SCO: begin
					job_q   <= job_q + 1'b1;
					state_q <= (job_q == 2'd3) ? ST_M1 : ST_RED;
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_A;
				ST_A: begin
					k_q     <= '0;
					pass_q  <= 1'b0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					k_q <= k_q + 1'b1;
					if (k_q == 5'd31) state_q <= pass_q ? ST_VIN : ST_SCL;
				end
				ST_SCL: state_q <= ST_M5;
				ST_M5:  state_q <= ST_SQ2I;
				ST_SQ2I: begin
					k_q     <= '0;
					pass_q  <= 1'b1;
					state_q <= ST_SQ;
				end
				ST_VIN: begin
					i_q     <= '0;
					vec_q   <= 1'b1;
					state_q <= ST_ROT;
				end
				ST_MD:  state_q <= ST_DST;
				ST_DST: state_q <= ST_OUT;
				ST_OUT: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/nph_select.sv -----
// ----------------------------------------------------------------------------
// nph_select: running minimum and result register
// Keeps the strictly smallest distance and its stream index, emits the
// result on the last candidate and clears the search.
// ----------------------------------------------------------------------------
module nph_select
	import nph_pkg::*;
#(
	parameter int MAX_POINTS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  nph_dist_t   res,
	input  logic        res_valid,
	output logic        res_ready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata
);

	localparam longint LIM_L = (longint'(MAX_POINTS) - 1 > 65535) ? 65535 :
		longint'(MAX_POINTS) - 1;
	localparam logic [IDX_W-1:0] IDX_LIM = IDX_W'(LIM_L);

	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [IDX_W-1:0]  count_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              take;
	logic              better;
	logic [DIST_W-1:0] new_dist;
	logic [IDX_W-1:0]  new_idx;

	// Hold a last item while the previous result still waits
	assign res_ready = !res.last || !out_valid_q || m_tready;
	assign take      = res_valid && res_ready;
	assign better    = res.distance < best_dist_q;
	assign new_dist  = better ? res.distance : best_dist_q;
	assign new_idx   = better ? count_q : best_idx_q;

	// found is always set: the last item is itself a candidate
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_dist_q, out_idx_q, 1'b1};

	always_ff @(posedge clk) begin
		if (take && res.last) begin
			out_idx_q  <= new_idx;
			out_dist_q <= new_dist;
		end
	end

	// Track the minimum, count candidates, clear on the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q <= '1;
			best_idx_q  <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && res.last) begin
				best_dist_q <= '1;
				best_idx_q  <= '0;
				count_q     <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (m_tready) out_valid_q <= 1'b0;
				if (take) begin
					best_dist_q <= new_dist;
					best_idx_q  <= new_idx;
					if (count_q < IDX_LIM) count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/nearest_point_haversine_unit.sv -----
// ----------------------------------------------------------------------------
// nearest_point_haversine_unit: nearest candidate by great-circle distance
// Streams candidate points against a configured query point and reports the
// nearest one, by haversine distance, when the last candidate arrives.
// ----------------------------------------------------------------------------
// The distance engine is built around the single shared CORDIC stage, the
// one-bit-a-cycle square roots (two passes of 32 steps) and the shared
// multiplier; candidates are handled one at a time. Up to four candidates
// queue ahead of the engine, and the result register lets the next search
// proceed while a result waits. Write the query registers only while idle.
module nearest_point_haversine_unit
	import nph_pkg::*;
#(
	parameter int MAX_POINTS      = 65536,
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // point_lat[23:0], point_lon[48:24], zero fill
	input  logic        s_tlast,   // last_point
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // found[0], best_index[16:1], best_distance[35:17]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [24:0] cfg_wdata
);

	logic signed [LAT_W-1:0] query_lat_q;
	logic signed [LON_W-1:0] query_lon_q;
	nph_item_t               item;
	logic                    item_valid;
	logic                    item_ready;
	nph_dist_t               dres;
	logic                    dres_valid;
	logic                    dres_ready;

	// Write query registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_lat_q <= '0;
			query_lon_q <= '0;
		end else if (cfg_we) begin
			unique case (nph_reg_t'(cfg_index))
				REG_QUERY_LAT: query_lat_q <= cfg_wdata[LAT_W-1:0];
				REG_QUERY_LON: query_lon_q <= cfg_wdata[LON_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nph_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready)
	);

	nph_dist #(
		.CORDIC_STEPS    (CORDIC_STEPS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.query_lat  (query_lat_q),
		.query_lon  (query_lon_q),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.res        (dres),
		.res_valid  (dres_valid),
		.res_ready  (dres_ready)
	);

	nph_select #(
		.MAX_POINTS (MAX_POINTS)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (dres),
		.res_valid (dres_valid),
		.res_ready (dres_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
